### hw/rtl/assert_macros.svh
// Assertion macros for the RTL of this project.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/tlg_pkg.sv
// Package for the tremolo LFO gain block: payload types, config codes,
// microcode word type and the microcode ROM. No dependencies.
package tlg_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int PHASE_BITS_DEF = 24;
    localparam int COEF_BITS_DEF  = 16;

    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    localparam int PHASE_STEP_RST = 2663;
    localparam int DEPTH_RST      = 32768;
    localparam int WAVE_MIX_RST   = 0;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_PHASE_STEP = 2'd0;
    localparam t_cfg_idx CFG_DEPTH      = 2'd1;
    localparam t_cfg_idx CFG_WAVE_MIX   = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          last_sample;
    } t_tlg_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          last_out;
    } t_tlg_out;

    // Microcode
    typedef logic [1:0] t_upc;

    localparam t_upc UPC_ACCEPT = 2'd0;
    localparam t_upc UPC_LFO    = 2'd1;
    localparam t_upc UPC_GAIN   = 2'd2;
    localparam t_upc UPC_EMIT   = 2'd3;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_TRI,
        MUL_LFO,
        MUL_SMP
    } t_mul_sel;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_WAIT_IN,
        JMP_WAIT_OUT
    } t_jmp;

    typedef struct packed {
        t_mul_sel mul_sel;
        t_jmp     jmp;
        logic     ld_in;
        logic     ld_out;
        t_upc     target;
    } t_mc_word;

    function automatic t_mc_word mc_rom(input t_upc upc);
        t_mc_word w;
        unique case (upc)
            UPC_ACCEPT: w = '{MUL_TRI,  JMP_WAIT_IN,  1'b1, 1'b0, UPC_LFO};
            UPC_LFO:    w = '{MUL_LFO,  JMP_NEXT,     1'b0, 1'b0, UPC_GAIN};
            UPC_GAIN:   w = '{MUL_SMP,  JMP_NEXT,     1'b0, 1'b0, UPC_EMIT};
            UPC_EMIT:   w = '{MUL_NONE, JMP_WAIT_OUT, 1'b0, 1'b1, UPC_ACCEPT};
            default:    w = '{MUL_NONE, JMP_NEXT,     1'b0, 1'b0, UPC_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

### hw/rtl/tremolo_lfo_gain_top.sv
// Tremolo LFO gain: microcoded sequencer around one shared multiplier.
// Depends on tlg_pkg and assert_macros.svh.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------
//  in      | input     | i_in_valid / o_in_stall    | i_in  (t_tlg_in)
//  out     | output    | o_out_valid / i_out_stall  | o_out (t_tlg_out)
//  cfg     | input     | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// Each transaction runs four steps: accept (triangle multiply), LFO multiply,
// sample multiply, result load; the three multiply steps share one multiplier.
// While an earlier result is still held by i_out_stall, a finished one waits
// in the last step; the next input is taken once that step is left.
// Synchronous reset clears phase, step counter and valid, and loads the
// config defaults.
`include "assert_macros.svh"

module tremolo_lfo_gain_top #(
    parameter int PHASE_BITS = tlg_pkg::PHASE_BITS_DEF,
    parameter int COEF_BITS  = tlg_pkg::COEF_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  tlg_pkg::t_tlg_in                    i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output tlg_pkg::t_tlg_out                   o_out,
    input  logic                                i_cfg_we,
    input  tlg_pkg::t_cfg_idx                   i_cfg_idx,
    input  logic [tlg_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import tlg_pkg::*;

    localparam int P   = PHASE_BITS;
    localparam int C   = COEF_BITS;
    localparam int AW  = (SAMPLE_BITS > C + 2) ? SAMPLE_BITS : C + 2;
    localparam int BW  = C + 2;
    localparam int PW  = AW + BW;
    localparam int TW  = P + C;

    localparam logic [C:0]   ONE       = {1'b1, {C{1'b0}}};
    localparam logic [C:0]   DEPTH_R   = (DEPTH_RST > (1 << C)) ? ONE : (C + 1)'(DEPTH_RST);
    localparam logic [C:0]   MIX_R     = (C + 1)'(WAVE_MIX_RST);
    localparam logic [P-1:0] STEP_R    = P'(PHASE_STEP_RST);

    // config
    logic [P-1:0] r_phase_step;
    logic [C:0]   r_depth;
    logic [C:0]   r_wave_mix;
    logic [31:0]  cfg_wide;

    assign cfg_wide = 32'(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= STEP_R;
            r_depth      <= DEPTH_R;
            r_wave_mix   <= MIX_R;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PHASE_STEP: r_phase_step <= cfg_wide[P-1:0];
                CFG_DEPTH:      r_depth      <= cfg_wide[C:0];
                CFG_WAVE_MIX:   r_wave_mix   <= cfg_wide[C:0];
                default: begin
                end
            endcase
        end
    end

    logic [C:0] depth_c;
    logic [C:0] mix_c;

    assign depth_c = (r_depth > ONE) ? ONE : r_depth;
    assign mix_c   = (r_wave_mix > ONE) ? ONE : r_wave_mix;

    // sequencer
    t_upc     r_upc, n_upc;
    t_mc_word mc;
    logic     in_acc;
    logic     out_free;
    logic     go;

    logic r_out_valid, n_out_valid;

    assign mc       = mc_rom(r_upc);
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_upc != UPC_ACCEPT);

    always_comb begin
        unique case (mc.jmp)
            JMP_NEXT:     go = 1'b1;
            JMP_WAIT_IN:  go = in_acc;
            JMP_WAIT_OUT: go = out_free;
            default:      go = 1'b0;
        endcase
        n_upc = go ? mc.target : r_upc;
        if (go && mc.ld_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= UPC_ACCEPT;
            r_out_valid <= 1'b0;
        end else begin
            r_upc       <= n_upc;
            r_out_valid <= n_out_valid;
        end
    end

    // phase and triangle
    logic [P-1:0] r_phase;
    logic [P-1:0] fold;
    logic [TW-1:0] fold_sh;
    logic [C:0]   tri_val;

    assign fold    = r_phase[P-1] ? (P'(0) - r_phase) : r_phase;
    assign fold_sh = {fold, {C{1'b0}}} >> (P - 1);
    assign tri_val = fold_sh[C:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (go && mc.ld_in) begin
            r_phase <= i_in.last_sample ? '0 : r_phase + r_phase_step;
        end
    end

    // datapath
    logic signed [SAMPLE_BITS-1:0] r_smp;
    logic                          r_last;
    logic                          r_sq;
    logic signed [PW-1:0]          r_prod;

    always_ff @(posedge i_clk) begin
        if (go && mc.ld_in) begin
            r_smp  <= i_in.sample_in;
            r_last <= i_in.last_sample;
            r_sq   <= !r_phase[P-1];
        end
    end

    logic [C:0]   sqw;
    logic [C+1:0] lfo_sum;
    logic [C+1:0] gain_sum;
    logic signed [AW-1:0] op_a;
    logic signed [BW-1:0] op_b;

    assign sqw      = r_sq ? mix_c : '0;
    assign lfo_sum  = {1'b0, r_prod[2*C:C]} + {1'b0, sqw};
    assign gain_sum = {1'b0, ONE - depth_c} + {1'b0, r_prod[2*C:C]};

    always_comb begin
        unique case (mc.mul_sel)
            MUL_TRI: begin
                op_a = AW'(tri_val);
                op_b = BW'(ONE - mix_c);
            end
            MUL_LFO: begin
                op_a = AW'(lfo_sum[C:0]);
                op_b = BW'(depth_c);
            end
            MUL_SMP: begin
                op_a = AW'(r_smp);
                op_b = BW'(gain_sum[C:0]);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (go && mc.mul_sel != MUL_NONE) begin
            r_prod <= op_a * op_b;
        end
    end

    // output register
    t_tlg_out r_out;

    always_ff @(posedge i_clk) begin
        if (go && mc.ld_out) begin
            r_out.sample_out <= r_prod[C +: SAMPLE_BITS];
            r_out.last_out   <= r_last;
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

    // checks
    `ASSERT_CLK(a_acc_next_step, i_clk, i_rst_n,
        in_acc |=> (r_upc == UPC_LFO), "accepted transaction did not start the program")
    `ASSERT_CLK(a_last_clears_phase, i_clk, i_rst_n,
        (in_acc && i_in.last_sample) |=> (r_phase == '0), "phase not cleared after last sample")
    `ASSERT_CLK(a_valid_from_emit, i_clk, i_rst_n,
        $rose(o_out_valid) |-> ($past(r_upc) == UPC_EMIT), "result shown outside emit step")
    `ASSERT_CLK(a_emit_leaves, i_clk, i_rst_n,
        ((r_upc == UPC_EMIT) && !r_out_valid) |=> (o_out_valid && r_upc == UPC_ACCEPT),
        "emit step with free output did not load")

endmodule

### dv/tremolo_gain_checker.sv
// Checker for the tremolo LFO gain block: tracks phase and registers, predicts each
// modulated sample and compares it with the output channel in order.
// Depends on tlg_pkg.
`timescale 1ns / 1ps

module tremolo_gain_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  tlg_pkg::t_tlg_in               i_in,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  tlg_pkg::t_tlg_out              i_out,
    input  logic                           i_cfg_we,
    input  tlg_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [tlg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_checked
);
    import tlg_pkg::*;

    localparam int COEF_W = COEF_BITS_DEF;
    localparam int PHASE_W = PHASE_BITS_DEF;
    localparam logic [63:0] UNITY = 64'd1 << COEF_W;
    localparam logic [PHASE_W-1:0] HALF_TURN = {1'b1, {(PHASE_W - 1){1'b0}}};

    logic [PHASE_W-1:0] lfo_phase;
    logic [PHASE_W-1:0] phase_step;
    logic [COEF_W:0]    depth_q;
    logic [COEF_W:0]    mix_q;
    t_tlg_out           expected_samples[$];
    int                 errors = 0;
    int                 checked = 0;

    function automatic t_tlg_out modulated_sample(input t_tlg_in x);
        logic [PHASE_W:0] fold;
        logic [63:0]      tri_lvl;
        logic [63:0]      sq_lvl;
        logic [63:0]      lfo;
        logic [63:0]      gain;
        logic [63:0]      d;
        logic [63:0]      w;
        longint           prod;
        t_tlg_out         r;
        d = (depth_q > UNITY) ? UNITY : 64'(depth_q);
        w = (mix_q > UNITY) ? UNITY : 64'(mix_q);
        if (lfo_phase < HALF_TURN) begin
            fold = {1'b0, lfo_phase};
            sq_lvl = UNITY;
        end else begin
            fold = ({1'b1, {PHASE_W{1'b0}}}) - {1'b0, lfo_phase};
            sq_lvl = 64'd0;
        end
        tri_lvl = (64'(fold) << COEF_W) >> (PHASE_W - 1);
        if (tri_lvl > UNITY) begin
            tri_lvl = UNITY;
        end
        lfo = ((UNITY - w) * tri_lvl + w * sq_lvl) >> COEF_W;
        gain = ((UNITY - d) * UNITY + d * lfo) >> COEF_W;
        // arithmetic shift floors toward minus infinity
        prod = longint'(x.sample_in) * longint'(gain);
        r.sample_out = SAMPLE_BITS'(prod >>> COEF_W);
        r.last_out = x.last_sample;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input longint want, input longint got);
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin : track
        t_tlg_out want;
        if (!i_rst_n) begin
            lfo_phase = '0;
            phase_step = PHASE_W'(PHASE_STEP_RST);
            depth_q = (COEF_W + 1)'(DEPTH_RST);
            mix_q = (COEF_W + 1)'(WAVE_MIX_RST);
            expected_samples.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_samples.size() == 0) begin
                    flag_mismatch("unexpected transaction, sample_out", 0, i_out.sample_out);
                end else begin
                    want = expected_samples.pop_front();
                    checked++;
                    if (i_out.sample_out !== want.sample_out) begin
                        flag_mismatch("sample_out", want.sample_out, i_out.sample_out);
                    end
                    if (i_out.last_out !== want.last_out) begin
                        flag_mismatch("last_out", want.last_out, i_out.last_out);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_samples.push_back(modulated_sample(i_in));
                lfo_phase = i_in.last_sample ? '0 : lfo_phase + phase_step;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PHASE_STEP: phase_step = i_cfg_data[PHASE_W-1:0];
                    CFG_DEPTH:      depth_q = i_cfg_data[COEF_W:0];
                    CFG_WAVE_MIX:   mix_q = i_cfg_data[COEF_W:0];
                    default: ;
                endcase
            end
        end
        o_errors <= errors;
        o_pending <= expected_samples.size();
        o_checked <= checked;
    end

endmodule

### dv/tb.sv
// Testbench top for tremolo_lfo_gain_top: clock, reset, register writes, bursty
// sample stimulus, receiver stalls, watchdog and verdict.
// Depends on tlg_pkg, tremolo_lfo_gain_top and tremolo_gain_checker.
`timescale 1ns / 1ps

module tb;
    import tlg_pkg::*;

    localparam int HOLD_CYCLES = 200;
    localparam int IDLE_LIMIT = 3000;
    localparam int SEGMENTS = 8;
    localparam int SEG_ITEMS = 80;
    localparam int SETTLE = 12;
    localparam t_cfg_idx CFG_UNUSED = 2'd3;
    localparam logic [CFG_DATA_W-1:0] COEF_UNITY = 24'h010000;

    typedef enum int {RX_FREE, RX_COIN, RX_LIGHT, RX_HEAVY} t_rx_mode;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_tlg_in               in_data = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_we = 1'b0;
    t_cfg_idx              cfg_idx = CFG_PHASE_STEP;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_stall;
    logic                  out_valid;
    t_tlg_out              out_data;
    int                    errors;
    int                    pending;
    int                    checked;

    int samples_sent = 0;
    int settings = 0;
    int hold_wanted = 0;
    int holds_done = 0;
    int idle_cycles = 0;
    int burst_left = 1;
    bit gaps_on = 1'b1;

    always #2 clk = ~clk;

    tremolo_lfo_gain_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    tremolo_gain_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in        (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out       (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stall patterns, plus long hold-offs on request
    initial begin : receiver
        t_rx_mode mode;
        int       len;
        @(posedge clk);
        forever begin
            if (holds_done < hold_wanted) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end else begin
                mode = t_rx_mode'($urandom_range(0, 3));
                len = $urandom_range(4, 60);
                repeat (len) begin
                    case (mode)
                        RX_FREE:  out_stall <= 1'b0;
                        RX_COIN:  out_stall <= 1'($urandom_range(0, 1));
                        RX_LIGHT: out_stall <= ($urandom_range(0, 4) == 0);
                        default:  out_stall <= ($urandom_range(0, 4) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic last);
        int gap;
        in_data <= '{sample_in: s, last_sample: last};
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        samples_sent++;
        if (gaps_on) begin
            burst_left--;
            if (burst_left <= 0) begin
                gap = $urandom_range(1, 12);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(1, 30);
            end
        end
    endtask

    // hold the sender until every outstanding transaction has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] step,
                             input logic [CFG_DATA_W-1:0] depth,
                             input logic [CFG_DATA_W-1:0] mix);
        write_reg(CFG_PHASE_STEP, step);
        write_reg(CFG_DEPTH, depth);
        write_reg(CFG_WAVE_MIX, mix);
        cfg_we <= 1'b0;
        settings++;
    endtask

    // Q1.16 coefficient, sometimes above one, sometimes with junk above bit 16
    function automatic logic [CFG_DATA_W-1:0] pick_coef();
        logic [CFG_DATA_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = COEF_UNITY;
            2:       v = CFG_DATA_W'($urandom_range(COEF_UNITY + 1, 24'h01FFFF));
            default: v = CFG_DATA_W'($urandom_range(0, COEF_UNITY));
        endcase
        if ($urandom_range(0, 3) == 0) begin
            v[CFG_DATA_W-1:COEF_BITS_DEF+1] = (CFG_DATA_W - COEF_BITS_DEF - 1)'($urandom);
        end
        return v;
    endfunction

    initial begin : stimulus
        int                            buf_len;
        int                            n;
        logic signed [SAMPLE_BITS-1:0] s;
        logic [CFG_DATA_W-1:0]         step;
        logic                          last;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        burst_left = $urandom_range(1, 30);

        // reset values of the registers
        send_sample(24'h7FFFFF, 1'b0);
        send_sample(24'h800000, 1'b0);
        send_sample(24'h000000, 1'b0);
        send_sample(24'hFFFFFF, 1'b1);

        // half-turn step: phase hits exactly one half
        drain();
        configure(24'h800000, COEF_UNITY, 24'h000000);
        send_sample(24'h7FFFFF, 1'b0);
        send_sample(24'h800000, 1'b0);
        send_sample(24'h7FFFFF, 1'b1);

        // depth and mix above one saturate, pure square
        drain();
        configure(24'h800000, 24'h01FFFF, 24'hFFFFFF);
        send_sample(24'h800000, 1'b0);
        send_sample(24'h7FFFFF, 1'b0);
        send_sample(24'hFFFFFF, 1'b1);

        // unused index ignored, zero depth, full-scale step
        drain();
        write_reg(CFG_UNUSED, 24'hFFFFFF);
        configure(24'hFFFFFF, 24'h000000, COEF_UNITY);
        send_sample(24'h000001, 1'b0);
        send_sample(24'hFFFFFE, 1'b0);
        send_sample(SAMPLE_BITS'($urandom), 1'b1);

        drain();
        configure(24'h555555, 24'h010001, 24'h008000);
        repeat (5) send_sample(SAMPLE_BITS'($urandom), 1'b0);
        send_sample(SAMPLE_BITS'($urandom), 1'b1);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain();
            case ($urandom_range(0, 5))
                0:       step = '0;
                1:       step = 24'hFFFFFF;
                2:       step = 24'h800000;
                3:       step = CFG_DATA_W'($urandom_range(1, 4000));
                default: step = CFG_DATA_W'($urandom);
            endcase
            if ($urandom_range(0, 2) == 0) begin
                write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
            end
            configure(step, pick_coef(), pick_coef());
            gaps_on = (seg != 3);
            if (seg == 2 || seg == 5) begin
                hold_wanted++;
            end
            n = 0;
            while (n < SEG_ITEMS) begin
                buf_len = $urandom_range(1, 40);
                if (buf_len > SEG_ITEMS - n) begin
                    buf_len = SEG_ITEMS - n;
                end
                for (int k = 0; k < buf_len; k++) begin
                    case ($urandom_range(0, 9))
                        0:       s = 24'h7FFFFF;
                        1:       s = 24'h800000;
                        2:       s = 24'($urandom_range(0, 7)) - 24'd4;
                        default: s = SAMPLE_BITS'($urandom);
                    endcase
                    last = (k == buf_len - 1);
                    if ($urandom_range(0, 15) == 0) begin
                        last = ~last;
                    end
                    send_sample(s, last);
                    n++;
                end
                if ($urandom_range(0, 14) == 0) begin
                    drain();
                end
            end
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        $display("Covered %0d samples over %0d register settings, %0d results compared,",
                 samples_sent, settings, checked);
        $display("with %0d long output hold-offs and buffer restarts throughout.", holds_done);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", errors);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
